// ----- src/lnc_pkg.sv -----
`default_nettype none

package lnc_pkg;

	// Default values of the top-level parameters.
	localparam int MAX_CLOCKS_PER_SAMPLE_DEF = 15;
	localparam int FRAC_BITS_DEF             = 24;

	// Field and register widths.
	localparam int STEP_W    = 28;
	localparam int LEVEL_W   = 4;
	localparam int SAMPLE_W  = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = STEP_W;

	// Shift register geometry.
	localparam int LFSR_W     = 15;
	localparam int TOP_TAP    = 14;
	localparam int NARROW_TAP = 6;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h7FFF;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STEP   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NARROW = 1'd1;

	// Input operation codes.
	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_TRIGGER = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic clock_step;
		logic load_out;
	} lnc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic trigger;
		logic go_clock;
		logic last_clock;
		logic out_free;
	} lnc_stat_t;

endpackage

`default_nettype wire

// ----- src/lfsr_noise_channel.sv -----
`default_nettype none

// Channel   Handshake            Payload
// config    cfg_write            cfg_index, cfg_data
// input     in_valid / in_ready  operation, env_level, env_active
// output    out_valid / out_ready sample_value
//
// A trigger item gives no result.
// A sample item goes through acceptance, n shift clocks and output load,
// where n is the number of whole phase units that overflow, capped at
// MAX_CLOCKS_PER_SAMPLE; the shift register is clocked once a cycle. Reset
// puts the register at all ones and clears phase, noise bit, voice and
// configuration. The next item is accepted while a result waits in the output
// register; a full output register stalls only the output step.

module lfsr_noise_channel #(
	parameter int MAX_CLOCKS_PER_SAMPLE = lnc_pkg::MAX_CLOCKS_PER_SAMPLE_DEF,
	parameter int FRAC_BITS             = lnc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [lnc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lnc_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           operation,
	input  wire logic [lnc_pkg::LEVEL_W-1:0]    env_level,
	input  wire logic                           env_active,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [lnc_pkg::SAMPLE_W-1:0] sample_value
);

	lnc_pkg::lnc_cmd_t  cmd;
	lnc_pkg::lnc_stat_t stat;

	// Sequencer for acceptance, shift clocks and output load.
	lnc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Registers, accumulator, shift register and output register.
	lnc_datapath #(
		.MAX_CLOCKS_PER_SAMPLE (MAX_CLOCKS_PER_SAMPLE),
		.FRAC_BITS             (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.env_level    (env_level),
		.env_active   (env_active),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_value (sample_value)
	);

endmodule

`default_nettype wire

// ----- src/lnc_ctrl.sv -----
`default_nettype none

module lnc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  lnc_pkg::lnc_stat_t     stat,
	output lnc_pkg::lnc_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLOCK = 2'd1;
	localparam logic [1:0] ST_OUT   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       in_fire;

	// An item is taken only while no earlier item is still being worked on.
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		cmd.accept     = 1'b0;
		cmd.clock_step = 1'b0;
		cmd.load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.accept = 1'b1;
					if (stat.trigger) begin
						state_d = ST_IDLE;
					end else if (stat.go_clock) begin
						state_d = ST_CLOCK;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_CLOCK: begin
				cmd.clock_step = 1'b1;
				if (stat.last_clock) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A trigger gives no result, so the controller stays ready for the next item.
	a_trigger_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && stat.trigger |=> state_q == ST_IDLE)
		else $error("trigger item did not return the controller to idle");

	// The shift loop ends in the output step, never straight back at idle.
	a_clock_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLOCK && stat.last_clock |=> state_q == ST_OUT)
		else $error("last shift clock did not lead to the output step");

	// A sample item always passes through the output step after its acceptance.
	a_sample_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !stat.trigger |=> state_q == ST_CLOCK || state_q == ST_OUT)
		else $error("sample item accepted without a result pending");

endmodule

`default_nettype wire

// ----- src/lnc_datapath.sv -----
`default_nettype none

module lnc_datapath #(
	parameter int MAX_CLOCKS_PER_SAMPLE = lnc_pkg::MAX_CLOCKS_PER_SAMPLE_DEF,
	parameter int FRAC_BITS             = lnc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [lnc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [lnc_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                operation,
	input  wire logic [lnc_pkg::LEVEL_W-1:0]         env_level,
	input  wire logic                                env_active,
	input  lnc_pkg::lnc_cmd_t                        cmd,
	output lnc_pkg::lnc_stat_t                       stat,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [lnc_pkg::SAMPLE_W-1:0]      sample_value
);

	localparam int STEP_W  = lnc_pkg::STEP_W;
	localparam int ACC_W   = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
	localparam int WHOLE_W = ACC_W - FRAC_BITS;
	localparam int CNT_W   = $clog2(MAX_CLOCKS_PER_SAMPLE + 1);
	localparam int CMP_W   = (WHOLE_W > CNT_W) ? WHOLE_W : CNT_W;

	// Configuration registers.
	logic [STEP_W-1:0]             step_q;
	logic                          narrow_q;

	// Voice state.
	logic [lnc_pkg::LFSR_W-1:0]    shift_q;
	logic [FRAC_BITS-1:0]          phase_q;
	logic                          noise_q;
	logic                          voice_on_q;
	logic [CNT_W-1:0]              count_q;

	// Item held for the output step.
	logic [lnc_pkg::LEVEL_W-1:0]   level_q;
	logic                          zero_q;

	// Output register.
	logic                          out_valid_q;
	logic signed [lnc_pkg::SAMPLE_W-1:0] sample_value_q;

	logic [ACC_W-1:0]              acc;
	logic [WHOLE_W-1:0]            whole;
	logic [CMP_W-1:0]              whole_ext;
	logic [CNT_W-1:0]              clocks;
	logic                          advance;
	logic                          feedback;
	logic [lnc_pkg::LFSR_W-1:0]    shift_next;
	logic [lnc_pkg::SAMPLE_W-1:0]  level_ext;
	logic [lnc_pkg::SAMPLE_W-1:0]  sample_next;

	// Phase accumulation and the clamped count of whole units that overflow.
	assign acc       = ACC_W'(phase_q) + ACC_W'(step_q);
	assign whole     = acc[ACC_W-1:FRAC_BITS];
	assign whole_ext = CMP_W'(whole);
	assign clocks    = (whole_ext > CMP_W'(MAX_CLOCKS_PER_SAMPLE)) ?
		CNT_W'(MAX_CLOCKS_PER_SAMPLE) : CNT_W'(whole_ext);

	// A sample item advances the voice only while it is on and the envelope runs.
	assign advance = (operation == lnc_pkg::OP_SAMPLE) && voice_on_q && env_active;

	// One shift register clock, with the narrow tap when selected.
	always_comb begin
		feedback   = shift_q[0] ^ shift_q[1];
		shift_next = {feedback, shift_q[lnc_pkg::LFSR_W-1:1]};
		if (narrow_q) begin
			shift_next[lnc_pkg::NARROW_TAP] = feedback;
		end
	end

	// Signed sample from the level and the noise bit.
	always_comb begin
		level_ext = {1'b0, level_q};
		if (zero_q) begin
			sample_next = '0;
		end else if (noise_q) begin
			sample_next = level_ext;
		end else begin
			sample_next = '0 - level_ext;
		end
	end

	// Status to the controller.
	assign stat.trigger    = (operation == lnc_pkg::OP_TRIGGER);
	assign stat.go_clock   = advance && (clocks != '0);
	assign stat.last_clock = (count_q == CNT_W'(1));
	assign stat.out_free   = !out_valid_q || out_ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			narrow_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				lnc_pkg::REG_STEP:   step_q   <= cfg_data[STEP_W-1:0];
				lnc_pkg::REG_NARROW: narrow_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Voice state: evaluated when an item is accepted, then clocked once a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= lnc_pkg::LFSR_SEED;
			phase_q    <= '0;
			noise_q    <= 1'b0;
			voice_on_q <= 1'b0;
			count_q    <= '0;
		end else if (cmd.accept) begin
			if (operation == lnc_pkg::OP_TRIGGER) begin
				shift_q    <= lnc_pkg::LFSR_SEED;
				phase_q    <= '0;
				noise_q    <= 1'b0;
				voice_on_q <= (step_q != '0);
				count_q    <= '0;
			end else if (voice_on_q && !env_active) begin
				voice_on_q <= 1'b0;
				count_q    <= '0;
			end else if (advance) begin
				phase_q <= acc[FRAC_BITS-1:0];
				count_q <= clocks;
			end
		end else if (cmd.clock_step) begin
			shift_q <= shift_next;
			noise_q <= !shift_next[0];
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Level and the forced-zero flag of the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			level_q <= env_level;
			zero_q  <= !advance;
		end
	end

	// Output register: holds one result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sample_value_q <= sample_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_value = sample_value_q;

	// A shift clock is only commanded while clocks remain for the item.
	a_clock_counted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clock_step |-> count_q != '0)
		else $error("shift clock commanded with no clocks left");

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid_q || out_ready)
		else $error("result loaded over a pending result");

	// A trigger restarts the shift register from its seed.
	a_trigger_seed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && operation == lnc_pkg::OP_TRIGGER |=>
		shift_q == lnc_pkg::LFSR_SEED && phase_q == '0)
		else $error("trigger did not restart the shift register");

endmodule

`default_nettype wire
